// ===== rtl/core/assert_macros.svh =====
// ----------------------------------------------------------------------------
// assert_macros
// Assertion macros used by the checker file of this block. Each macro
// expands to one labelled concurrent assertion that reports by $error.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, switched off while reset is asserted.
`define HBCD_ASSERT(name, clk, rst_n, prop) \
  name: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("hbcd assertion failed");

// Clocked assertion that must also hold during reset.
`define HBCD_ASSERT_ALWAYS(name, clk, prop) \
  name: assert property (@(posedge clk) prop) \
    else $error("hbcd assertion failed");

`endif

// ===== rtl/core/hbcd_pkg.sv =====
// ----------------------------------------------------------------------------
// hbcd_pkg
// Shared codes, character constants and the result type of the HTTP body
// chunk deframer.
// ----------------------------------------------------------------------------
package hbcd_pkg;

  // Input item kinds.
  localparam logic [1:0] MODE_BYTE   = 2'd0;
  localparam logic [1:0] MODE_LEN    = 2'd1;
  localparam logic [1:0] MODE_CHUNK  = 2'd2;
  localparam logic [1:0] MODE_UNUSED = 2'd3;

  // Framing phases.
  localparam logic [2:0] PH_IDLE  = 3'd0;
  localparam logic [2:0] PH_DATA  = 3'd1;
  localparam logic [2:0] PH_HEAD  = 3'd2;
  localparam logic [2:0] PH_CDATA = 3'd3;
  localparam logic [2:0] PH_TRAIL = 3'd4;

  // Characters that matter on size and trailer lines.
  localparam logic [7:0] CH_CR  = 8'h0D;
  localparam logic [7:0] CH_LF  = 8'h0A;
  localparam logic [7:0] CH_SP  = 8'h20;
  localparam logic [7:0] CH_TAB = 8'h09;
  localparam logic [7:0] CH_VT  = 8'h0B;
  localparam logic [7:0] CH_FF  = 8'h0C;

  typedef struct packed {
    logic       payload_valid;
    logic [7:0] payload_byte;
    logic       body_done;
    logic       framing_error;
  } hbcd_res_t;

endpackage

// ===== rtl/core/hbcd_if.sv =====
// ----------------------------------------------------------------------------
// hbcd_in_if / hbcd_out_if
// Valid/ready channels carrying input items and result items.
// ----------------------------------------------------------------------------
interface hbcd_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  mode;
  logic [7:0]  data_byte;
  logic [31:0] body_length;

  modport source (output valid, output mode, output data_byte, output body_length,
                  input ready);
  modport sink   (input valid, input mode, input data_byte, input body_length,
                  output ready);
endinterface

interface hbcd_out_if;
  logic       valid;
  logic       ready;
  logic       payload_valid;
  logic [7:0] payload_byte;
  logic       body_done;
  logic       framing_error;

  modport source (output valid, output payload_valid, output payload_byte,
                  output body_done, output framing_error, input ready);
  modport sink   (input valid, input payload_valid, input payload_byte,
                  input body_done, input framing_error, output ready);
endinterface

// ===== rtl/core/http_body_chunk_deframer.sv =====
// ----------------------------------------------------------------------------
// http_body_chunk_deframer
// Pulls the payload bytes out of an HTTP/1.1 response body framed either by
// a known length or by chunked transfer coding.
// ----------------------------------------------------------------------------
//
//   Channel  Dir  Payload                                 Each transfer
//   in_i     in   mode, data_byte, body_length            one start or one byte
//   out_o    out  payload_valid, payload_byte,            one result per input
//                 body_done, framing_error
//
// While in_i.ready is high, one input transfer is taken every cycle; each
// yields exactly one result. The state update is a single pass of logic
// between the framing registers and the result register.
// The result register is backed by one skid entry: in_i.ready falls only
// when both hold a result that the sink has not yet taken.
// Reset is asynchronous and active low; it returns the framing to idle and
// empties the result path.
//
// A start transfer selects length mode (exactly body_length payload bytes)
// or chunked mode. In chunked mode the block reads a hexadecimal size line,
// skipping blank lines before it, passes that many payload bytes and then
// expects the next size line. A size of zero is followed by trailer lines,
// which are dropped until an empty line ends the body. A size line with no
// hexadecimal digit, or one whose value will not fit in LEN_BITS bits, flags
// a framing error and the block returns to idle. Body bytes that arrive
// while idle produce an empty result.
module http_body_chunk_deframer #(
  parameter int unsigned LEN_BITS = 32
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  hbcd_in_if.sink    in_i,
  hbcd_out_if.source out_o
);
  import hbcd_pkg::*;

  logic      accept;
  logic      buf_ready;
  hbcd_res_t res;

  // The framing state advances only on an accepted input transfer.
  assign in_i.ready = buf_ready;
  assign accept     = in_i.valid && buf_ready;

  hbcd_core #(
    .LEN_BITS (LEN_BITS)
  ) u_core (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .accept_i      (accept),
    .mode_i        (in_i.mode),
    .data_byte_i   (in_i.data_byte),
    .body_length_i (in_i.body_length),
    .res_o         (res)
  );

  // The result of each accepted transfer is captured in the output buffer in
  // the same cycle; it then waits there for the sink. The next input transfer
  // is held up only while the result register and skid entry are both full.
  hbcd_obuf u_obuf (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (accept),
    .res_i   (res),
    .ready_o (buf_ready),
    .out_o   (out_o)
  );

endmodule

// ===== rtl/core/hbcd_core.sv =====
// ----------------------------------------------------------------------------
// hbcd_core
// Framing state and the single-pass update that turns one input item into
// one result.
// ----------------------------------------------------------------------------
module hbcd_core #(
  parameter int unsigned LEN_BITS = 32
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 accept_i,
  input  logic [1:0]           mode_i,
  input  logic [7:0]           data_byte_i,
  input  logic [31:0]          body_length_i,
  output hbcd_pkg::hbcd_res_t  res_o
);
  import hbcd_pkg::*;

  logic [2:0]          phase_q, phase_d, phase_cur;
  logic [LEN_BITS-1:0] rem_q, rem_d, rem_dec;
  logic [LEN_BITS-1:0] acc_q, acc_d;
  logic                digit_q, digit_d;
  logic                ended_q, ended_d;
  logic                cr_q, cr_d;
  logic                text_q, text_d;
  logic [LEN_BITS-1:0] blen_sat;
  logic                is_hex, is_space, acc_full, line_end, clr;
  logic [3:0]          hex_val;
  logic                text_tmp, ended_tmp;
  hbcd_res_t           res;

  // Body length saturates to the largest count when the count is narrower.
  if (LEN_BITS >= 32) begin : g_len_wide
    assign blen_sat = LEN_BITS'(body_length_i);
  end else begin : g_len_narrow
    assign blen_sat = (body_length_i[31:LEN_BITS] != '0) ? '1
                                                          : body_length_i[LEN_BITS-1:0];
  end

  always_comb begin
    is_hex  = 1'b1;
    hex_val = data_byte_i[3:0];
    if (data_byte_i >= "0" && data_byte_i <= "9") begin
      hex_val = data_byte_i[3:0];
    end else if ((data_byte_i >= "a" && data_byte_i <= "f") ||
                 (data_byte_i >= "A" && data_byte_i <= "F")) begin
      hex_val = 4'(data_byte_i[2:0] + 3'd1) + 4'd8;
    end else begin
      is_hex = 1'b0;
    end
  end

  assign is_space = (data_byte_i == CH_SP) || (data_byte_i == CH_TAB) ||
                    (data_byte_i == CH_LF) || (data_byte_i == CH_VT) ||
                    (data_byte_i == CH_FF) || (data_byte_i == CH_CR);
  assign acc_full  = acc_q[LEN_BITS-1 -: 4] != 4'd0;
  assign line_end  = cr_q && (data_byte_i == CH_LF);
  assign phase_cur = (phase_q > PH_TRAIL) ? PH_IDLE : phase_q;
  assign rem_dec   = rem_q - LEN_BITS'(1);

  always_comb begin
    phase_d   = phase_cur;
    rem_d     = rem_q;
    acc_d     = acc_q;
    digit_d   = digit_q;
    ended_d   = ended_q;
    cr_d      = cr_q;
    text_d    = text_q;
    clr       = 1'b0;
    res       = '0;
    text_tmp  = text_q;
    ended_tmp = ended_q;

    unique case (mode_i)
      MODE_LEN: begin
        clr   = 1'b1;
        rem_d = blen_sat;
        if (blen_sat == '0) begin
          phase_d       = PH_IDLE;
          res.body_done = 1'b1;
        end else begin
          phase_d = PH_DATA;
        end
      end
      MODE_CHUNK: begin
        clr     = 1'b1;
        rem_d   = '0;
        phase_d = PH_HEAD;
      end
      MODE_BYTE: begin
        unique case (phase_cur) inside
          PH_DATA, PH_CDATA: begin
            res.payload_valid = 1'b1;
            res.payload_byte  = data_byte_i;
            rem_d             = rem_dec;
            if (rem_dec == '0) begin
              clr = 1'b1;
              if (phase_cur == PH_DATA) begin
                phase_d       = PH_IDLE;
                res.body_done = 1'b1;
              end else begin
                phase_d = PH_HEAD;
              end
            end
          end
          PH_HEAD: begin
            if (line_end) begin
              clr = 1'b1;
              if (text_q && !digit_q) begin
                res.framing_error = 1'b1;
                phase_d           = PH_IDLE;
              end else if (text_q) begin
                rem_d   = acc_q;
                phase_d = (acc_q == '0) ? PH_TRAIL : PH_CDATA;
              end
            end else begin
              // A held CR that was not followed by LF is a whitespace character.
              if (cr_q) begin
                text_tmp = 1'b1;
                if (digit_q) begin
                  ended_tmp = 1'b1;
                end
              end
              cr_d    = 1'b0;
              text_d  = text_tmp;
              ended_d = ended_tmp;
              if (data_byte_i == CH_CR) begin
                cr_d = 1'b1;
              end else begin
                text_d = 1'b1;
                if (!ended_tmp) begin
                  if (is_hex) begin
                    if (acc_full) begin
                      res.framing_error = 1'b1;
                      phase_d           = PH_IDLE;
                      clr               = 1'b1;
                    end else begin
                      acc_d   = {acc_q[LEN_BITS-5:0], hex_val};
                      digit_d = 1'b1;
                    end
                  end else if (digit_q || !is_space) begin
                    ended_d = 1'b1;
                  end
                end
              end
            end
          end
          PH_TRAIL: begin
            if (line_end) begin
              clr = 1'b1;
              if (!text_q) begin
                res.body_done = 1'b1;
                phase_d       = PH_IDLE;
              end
            end else begin
              cr_d   = (data_byte_i == CH_CR);
              text_d = text_q || cr_q || (data_byte_i != CH_CR);
            end
          end
          default: begin
          end
        endcase
      end
      default: begin
        phase_d = phase_cur;
      end
    endcase

    if (clr) begin
      acc_d   = '0;
      digit_d = 1'b0;
      ended_d = 1'b0;
      cr_d    = 1'b0;
      text_d  = 1'b0;
    end
  end

  assign res_o = res;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_IDLE;
      rem_q   <= '0;
      acc_q   <= '0;
      digit_q <= 1'b0;
      ended_q <= 1'b0;
      cr_q    <= 1'b0;
      text_q  <= 1'b0;
    end else if (accept_i) begin
      phase_q <= phase_d;
      rem_q   <= rem_d;
      acc_q   <= acc_d;
      digit_q <= digit_d;
      ended_q <= ended_d;
      cr_q    <= cr_d;
      text_q  <= text_d;
    end
  end

endmodule

// ===== rtl/core/hbcd_obuf.sv =====
// ----------------------------------------------------------------------------
// hbcd_obuf
// Result register with one skid entry, so that input ready is registered
// and does not follow output ready combinationally.
// ----------------------------------------------------------------------------
module hbcd_obuf (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push_i,
  input  hbcd_pkg::hbcd_res_t res_i,
  output logic                ready_o,
  hbcd_out_if.source          out_o
);
  import hbcd_pkg::*;

  logic      out_valid_q, skid_valid_q;
  hbcd_res_t out_q, skid_q;
  logic      pop;

  assign pop     = out_valid_q && out_o.ready;
  assign ready_o = !skid_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else if (skid_valid_q) begin
      if (pop) begin
        skid_valid_q <= 1'b0;
      end
    end else if (!out_valid_q || pop) begin
      out_valid_q <= push_i;
    end else if (push_i) begin
      skid_valid_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (skid_valid_q) begin
      if (pop) begin
        out_q <= skid_q;
      end
    end else if (!out_valid_q || pop) begin
      out_q <= res_i;
    end else if (push_i) begin
      skid_q <= res_i;
    end
  end

  assign out_o.valid         = out_valid_q;
  assign out_o.payload_valid = out_q.payload_valid;
  assign out_o.payload_byte  = out_q.payload_byte;
  assign out_o.body_done     = out_q.body_done;
  assign out_o.framing_error = out_q.framing_error;

endmodule

// ===== rtl/core/hbcd_checker.sv =====
// ----------------------------------------------------------------------------
// hbcd_checker
// Port-level assertions for the HTTP body chunk deframer, bound to the top.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module hbcd_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       in_valid_i,
  input logic       in_ready_i,
  input logic       out_valid_i,
  input logic       out_ready_i,
  input logic       payload_valid_i,
  input logic [7:0] payload_byte_i,
  input logic       body_done_i,
  input logic       framing_error_i
);

  logic err_shown;
  logic empty_shown;
  logic in_xfer;

  assign err_shown   = out_valid_i && framing_error_i;
  assign empty_shown = out_valid_i && !payload_valid_i;
  assign in_xfer     = in_valid_i && in_ready_i;

  // A framing error never carries a payload byte or completes a body.
  `HBCD_ASSERT(a_err_alone, clk_i, rst_ni, err_shown |-> (!payload_valid_i && !body_done_i))

  // An empty result carries a zero byte.
  `HBCD_ASSERT(a_empty_zero, clk_i, rst_ni, empty_shown |-> (payload_byte_i == 8'd0))

  // Input back-pressure only appears while a result is waiting.
  `HBCD_ASSERT_ALWAYS(a_ready_low_waits, clk_i, !in_ready_i |-> out_valid_i)

  // A result appears only after an input transfer.
  `HBCD_ASSERT(a_result_follows_input, clk_i, rst_ni, $rose(out_valid_i) |-> $past(in_xfer))

  // A stalled result stays presented.
  `HBCD_ASSERT(a_stall_holds, clk_i, rst_ni, (out_valid_i && !out_ready_i) |=> out_valid_i)

endmodule

bind http_body_chunk_deframer hbcd_checker u_hbcd_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .in_valid_i      (in_i.valid),
  .in_ready_i      (in_i.ready),
  .out_valid_i     (out_o.valid),
  .out_ready_i     (out_o.ready),
  .payload_valid_i (out_o.payload_valid),
  .payload_byte_i  (out_o.payload_byte),
  .body_done_i     (out_o.body_done),
  .framing_error_i (out_o.framing_error)
);

// ===== bench/http_body_chunk_deframer_tb.sv =====
// ----------------------------------------------------------------------------
// http_body_chunk_deframer_tb
// Self-checking bench for the HTTP body chunk deframer. A directed opening
// covers the corner cases of both framings. Random length-framed and chunked
// bodies follow, mixed with broken size lines and noise. A behavioural
// model predicts one result per input transfer, and every output transfer
// is compared field by field against the oldest prediction.
// ----------------------------------------------------------------------------
module http_body_chunk_deframer_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import hbcd_pkg::*;

  localparam int unsigned LEN_BITS       = 32;
  localparam int unsigned ITEM_TARGET    = 1600;
  // A transfer-free stretch this long means the block has hung.
  localparam int unsigned STALL_LIMIT    = 2000;
  // The long receiver hold-off starts after this many results.
  localparam int unsigned PRESSURE_AFTER = 300;
  localparam int unsigned HOLD_CYCLES    = 400;
  localparam int unsigned DRAIN_CYCLES   = 20;

  // ASCII characters used to build size lines, besides those in the package.
  localparam logic [7:0] CH_ZERO = 8'h30;
  localparam logic [7:0] CH_TWO  = 8'h32;
  localparam logic [7:0] CH_SEMI = 8'h3B;
  localparam logic [7:0] CH_G    = 8'h67;
  localparam logic [7:0] CH_Z    = 8'h7A;
  localparam logic [7:0] CH_T    = 8'h54;
  localparam logic [7:0] CH_X    = 8'h78;

  typedef struct packed {
    logic [1:0]  mode;
    logic [7:0]  data_byte;
    logic [31:0] body_length;
  } body_item_t;

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  hbcd_in_if  in_bus ();
  hbcd_out_if out_bus ();

  http_body_chunk_deframer #(
    .LEN_BITS(LEN_BITS)
  ) dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_i  (in_bus),
    .out_o (out_bus)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // Stimulus waiting to be sent, and results predicted but not yet seen.
  body_item_t  body_items_to_send[$];
  hbcd_res_t   predicted_results[$];

  body_item_t  cur_item = '0;
  bit          offering = 1'b0;
  bit          in_fire  = 1'b0;
  bit          out_fire = 1'b0;
  int unsigned send_gap = 0;
  int unsigned recv_gap = 0;
  int unsigned hold_left = 0;
  bit          pressure_done = 1'b0;
  int unsigned results_seen = 0;
  int unsigned cycle_count = 0;
  int unsigned quiet_cycles = 0;
  int unsigned fail_count = 0;

  // --------------------------------------------------------------------------
  // Behavioural model of the framing state. It starts from the reset state,
  // and reset is applied only once, so no explicit reset of it is needed.
  // --------------------------------------------------------------------------
  logic [2:0]          pr_phase     = PH_IDLE;
  logic [LEN_BITS-1:0] pr_remaining = '0;
  logic [LEN_BITS-1:0] pr_size      = '0;
  bit                  pr_digit     = 1'b0;
  bit                  pr_field_end = 1'b0;
  bit                  pr_cr        = 1'b0;
  bit                  pr_text      = 1'b0;

  function automatic void clear_line();
    pr_size      = '0;
    pr_digit     = 1'b0;
    pr_field_end = 1'b0;
    pr_cr        = 1'b0;
    pr_text      = 1'b0;
  endfunction

  // Feeds one text character of a size line; returns 1 when it is a digit
  // that would no longer fit in LEN_BITS bits.
  function automatic bit size_char(logic [7:0] c);
    bit         is_hex;
    logic [3:0] v;
    pr_text = 1'b1;
    if (pr_field_end) return 1'b0;
    is_hex = 1'b1;
    v      = '0;
    if (c >= 8'h30 && c <= 8'h39) v = c[3:0];
    else if ((c >= 8'h61 && c <= 8'h66) || (c >= 8'h41 && c <= 8'h46)) v = c[3:0] + 4'd9;
    else is_hex = 1'b0;
    if (is_hex) begin
      if (pr_size[LEN_BITS-1 -: 4] != 4'd0) return 1'b1;
      pr_size  = {pr_size[LEN_BITS-5:0], v};
      pr_digit = 1'b1;
      return 1'b0;
    end
    // Whitespace ahead of the first digit is skipped; anything else closes
    // the size field and the rest of the line is an extension.
    if (!pr_digit && (c == CH_SP || c == CH_TAB || c == CH_LF || c == CH_VT ||
                      c == CH_FF || c == CH_CR)) return 1'b0;
    pr_field_end = 1'b1;
    return 1'b0;
  endfunction

  function automatic hbcd_res_t deframe_step(body_item_t it);
    hbcd_res_t   r;
    bit          ovf;
    logic [63:0] wide_len;
    logic [63:0] len_max;
    r = '0;
    if (pr_phase > PH_TRAIL) pr_phase = PH_IDLE;
    case (it.mode)
      MODE_LEN: begin
        clear_line();
        wide_len = 64'(it.body_length);
        len_max  = '1;
        len_max  = len_max >> (64 - LEN_BITS);
        pr_remaining = (wide_len > len_max) ? len_max[LEN_BITS-1:0] : wide_len[LEN_BITS-1:0];
        if (pr_remaining == '0) begin
          // A zero-length body completes on its own start transfer.
          pr_phase    = PH_IDLE;
          r.body_done = 1'b1;
        end else begin
          pr_phase = PH_DATA;
        end
      end
      MODE_CHUNK: begin
        clear_line();
        pr_remaining = '0;
        pr_phase     = PH_HEAD;
      end
      MODE_BYTE: begin
        if (pr_phase == PH_DATA || pr_phase == PH_CDATA) begin
          r.payload_valid = 1'b1;
          r.payload_byte  = it.data_byte;
          pr_remaining    = pr_remaining - 1'b1;
          if (pr_remaining == '0) begin
            if (pr_phase == PH_DATA) begin
              pr_phase    = PH_IDLE;
              r.body_done = 1'b1;
            end else begin
              pr_phase = PH_HEAD;
            end
            clear_line();
          end
        end else if (pr_phase == PH_HEAD) begin
          if (pr_cr && it.data_byte == CH_LF) begin
            if (!pr_text) begin
              clear_line();
            end else if (!pr_digit) begin
              r.framing_error = 1'b1;
              pr_phase        = PH_IDLE;
              clear_line();
            end else begin
              pr_remaining = pr_size;
              pr_phase     = (pr_size == '0) ? PH_TRAIL : PH_CDATA;
              clear_line();
            end
          end else begin
            // A CR not followed by LF counts as an ordinary whitespace byte.
            ovf = 1'b0;
            if (pr_cr) ovf = size_char(CH_CR);
            pr_cr = 1'b0;
            if (!ovf) begin
              if (it.data_byte == CH_CR) pr_cr = 1'b1;
              else ovf = size_char(it.data_byte);
            end
            if (ovf) begin
              r.framing_error = 1'b1;
              pr_phase        = PH_IDLE;
              clear_line();
            end
          end
        end else if (pr_phase == PH_TRAIL) begin
          if (pr_cr && it.data_byte == CH_LF) begin
            if (!pr_text) begin
              r.body_done = 1'b1;
              pr_phase    = PH_IDLE;
            end
            clear_line();
          end else begin
            if (pr_cr) pr_text = 1'b1;
            pr_cr = 1'b0;
            if (it.data_byte == CH_CR) pr_cr = 1'b1;
            else pr_text = 1'b1;
          end
        end
      end
      default: begin
        // The unused mode leaves the framing untouched.
      end
    endcase
    return r;
  endfunction

  // --------------------------------------------------------------------------
  // Stimulus construction.
  // --------------------------------------------------------------------------
  task automatic push(logic [1:0] m, logic [7:0] b, logic [31:0] len);
    body_item_t it;
    it.mode        = m;
    it.data_byte   = b;
    it.body_length = len;
    body_items_to_send.push_back(it);
  endtask

  // The length field is ignored on a byte transfer, so it carries noise.
  task automatic push_byte(logic [7:0] b);
    push(MODE_BYTE, b, $urandom());
  endtask

  task automatic push_crlf();
    push_byte(CH_CR);
    push_byte(CH_LF);
  endtask

  // Any byte except CR, so that it can never close a line by accident.
  function automatic logic [7:0] text_byte();
    logic [7:0] b;
    b = 8'($urandom());
    if (b == CH_CR) b = CH_SP;
    return b;
  endfunction

  function automatic logic [7:0] hex_char(logic [3:0] v);
    if (v < 4'd10) return CH_ZERO + v;
    if ($urandom_range(0, 1) != 0) return 8'h61 + v - 4'd10;
    return 8'h41 + v - 4'd10;
  endfunction

  // Whitespace that a size line may start with. A lone CR is allowed, but
  // never directly before an LF, since that would end the line.
  task automatic push_leading_space(int unsigned n);
    logic [7:0] c;
    bit         prev_cr;
    prev_cr = 1'b0;
    repeat (n) begin
      case ($urandom_range(0, 5))
        0:       c = CH_SP;
        1:       c = CH_TAB;
        2:       c = CH_LF;
        3:       c = CH_VT;
        4:       c = CH_FF;
        default: c = CH_CR;
      endcase
      if (prev_cr && c == CH_LF) c = CH_SP;
      push_byte(c);
      prev_cr = (c == CH_CR);
    end
  endtask

  task automatic gen_length_body();
    int unsigned len;
    int unsigned sent;
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 10) len = 0;
    else if (r < 80) len = $urandom_range(1, 8);
    else if (r < 95) len = $urandom_range(9, 40);
    else len = $urandom() | 32'h8000_0000;
    push(MODE_LEN, 8'($urandom()), len);
    // Huge bodies are only begun; the next start abandons them.
    sent = (len > 40) ? $urandom_range(1, 6) : len;
    if (len != 0 && len <= 40 && $urandom_range(0, 99) < 8) sent = $urandom_range(0, len - 1);
    repeat (sent) push_byte(8'($urandom()));
  endtask

  task automatic gen_chunked_body();
    int unsigned n_chunks;
    int unsigned size;
    int unsigned ndig;
    int unsigned r;
    push(MODE_CHUNK, 8'($urandom()), $urandom());
    n_chunks = $urandom_range(0, 3);
    for (int c = 0; c <= n_chunks; c++) begin
      r = $urandom_range(0, 99);
      if (c == n_chunks) size = 0;
      else if (r < 85) size = $urandom_range(1, 12);
      else if (r < 97) size = $urandom_range(13, 40);
      else size = $urandom() | 32'h1000_0000;
      // Blank lines, then the size line itself.
      repeat ($urandom_range(0, 2)) push_crlf();
      push_leading_space($urandom_range(0, 1) * $urandom_range(1, 3));
      repeat ($urandom_range(0, 2)) push_byte(CH_ZERO);
      ndig = 1;
      while (ndig < 8 && (size >> (4 * ndig)) != 0) ndig++;
      for (int k = ndig - 1; k >= 0; k--) push_byte(hex_char(4'(size >> (4 * k))));
      if ($urandom_range(0, 99) < 30) begin
        push_byte(CH_SEMI);
        repeat ($urandom_range(0, 4)) push_byte(text_byte());
      end
      push_crlf();
      if (size > 40) begin
        repeat ($urandom_range(1, 5)) push_byte(8'($urandom()));
        return;
      end
      if (size != 0) begin
        if ($urandom_range(0, 99) < 5) begin
          repeat ($urandom_range(0, size - 1)) push_byte(8'($urandom()));
          return;
        end
        repeat (size) push_byte(8'($urandom()));
      end
    end
    // Trailer lines after the last chunk, then the empty line that ends it.
    repeat ($urandom_range(0, 2)) begin
      repeat ($urandom_range(1, 6)) push_byte(text_byte());
      push_crlf();
    end
    push_crlf();
  endtask

  // Random pauses: mostly none or short, a few long. A stretch that recurs
  // through the run has no pauses at all.
  function automatic int unsigned gap_len();
    int unsigned r;
    if (cycle_count % 1024 < 200) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 88) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // --------------------------------------------------------------------------
  // Sender: presents the next pending item on the falling edge. A transfer
  // seen at the rising edge retires the current item, and the next one, if
  // there is no pause, follows without valid dropping in between.
  // --------------------------------------------------------------------------
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (in_fire) begin
        in_fire  = 1'b0;
        offering = 1'b0;
      end
      if (!offering) begin
        if (send_gap != 0) begin
          send_gap = send_gap - 1;
        end else if (body_items_to_send.size() != 0) begin
          cur_item = body_items_to_send.pop_front();
          offering = 1'b1;
          send_gap = gap_len();
        end
      end
      in_bus.valid       <= offering;
      in_bus.mode        <= cur_item.mode;
      in_bus.data_byte   <= cur_item.data_byte;
      in_bus.body_length <= cur_item.body_length;
    end
  end

  // --------------------------------------------------------------------------
  // Receiver: pauses after transfers at random. Once, it holds ready low for
  // a long stretch so that the result path fills and in_i.ready falls while
  // the sender keeps offering.
  // --------------------------------------------------------------------------
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (out_fire) begin
        out_fire = 1'b0;
        recv_gap = gap_len();
      end
      if (!pressure_done && results_seen >= PRESSURE_AFTER) begin
        pressure_done = 1'b1;
        hold_left     = HOLD_CYCLES;
      end
      if (hold_left != 0) begin
        hold_left = hold_left - 1;
        out_bus.ready <= 1'b0;
      end else if (recv_gap != 0) begin
        recv_gap = recv_gap - 1;
        out_bus.ready <= 1'b0;
      end else begin
        out_bus.ready <= 1'b1;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Monitor: at each rising edge an input transfer is run through the model
  // and an output transfer is checked against the oldest prediction. The
  // watchdog counts edges on which neither channel moves.
  // --------------------------------------------------------------------------
  always @(posedge clk_i) begin
    hbcd_res_t got;
    hbcd_res_t want;
    bit        moved;
    if (rst_ni) begin
      cycle_count++;
      moved = 1'b0;
      if (in_bus.valid && in_bus.ready) begin
        predicted_results.push_back(deframe_step(cur_item));
        in_fire = 1'b1;
        moved   = 1'b1;
      end
      if (out_bus.valid && out_bus.ready) begin
        out_fire = 1'b1;
        moved    = 1'b1;
        results_seen++;
        got.payload_valid = out_bus.payload_valid;
        got.payload_byte  = out_bus.payload_byte;
        got.body_done     = out_bus.body_done;
        got.framing_error = out_bus.framing_error;
        if (predicted_results.size() == 0) begin
          $error("result transfer with no prediction waiting: %p", got);
          fail_count++;
        end else begin
          want = predicted_results.pop_front();
          if (got.payload_valid !== want.payload_valid) begin
            $error("payload_valid: expected %0d, got %0d", want.payload_valid,
                   got.payload_valid);
            fail_count++;
          end
          if (got.payload_byte !== want.payload_byte) begin
            $error("payload_byte: expected %02h, got %02h", want.payload_byte, got.payload_byte);
            fail_count++;
          end
          if (got.body_done !== want.body_done) begin
            $error("body_done: expected %0d, got %0d", want.body_done, got.body_done);
            fail_count++;
          end
          if (got.framing_error !== want.framing_error) begin
            $error("framing_error: expected %0d, got %0d", want.framing_error,
                   got.framing_error);
            fail_count++;
          end
        end
      end
      quiet_cycles = moved ? 0 : quiet_cycles + 1;
      if (quiet_cycles >= STALL_LIMIT) begin
        $error("no transfer for %0d cycles", quiet_cycles);
        $display("Test completed with failures");
        $finish;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Stimulus and end of run.
  // --------------------------------------------------------------------------
  initial begin
    int unsigned pick;
    in_bus.valid       = 1'b0;
    in_bus.mode        = MODE_BYTE;
    in_bus.data_byte   = '0;
    in_bus.body_length = '0;
    out_bus.ready      = 1'b0;

    // Directed opening. Bytes while idle and the unused mode yield empty results.
    push_byte(8'h00);
    push_byte(8'hFF);
    push(MODE_UNUSED, 8'hFF, 32'hFFFF_FFFF);
    // Zero-length body, then the longest length, abandoned after one byte.
    push(MODE_LEN, 8'h00, 32'd0);
    push(MODE_LEN, 8'hFF, 32'hFFFF_FFFF);
    push_byte(8'h5A);
    // Chunked restart: a blank line, a tab and a lone CR ahead of the size,
    // an extension, two payload bytes, the zero chunk, one trailer line and
    // the closing empty line.
    push(MODE_CHUNK, 8'h00, 32'd0);
    push_crlf();
    push_byte(CH_TAB);
    push_byte(CH_CR);
    push_byte(CH_TWO);
    push_byte(CH_SEMI);
    push_byte(CH_X);
    push_crlf();
    push_byte(8'h00);
    push_byte(8'hFF);
    push_byte(CH_ZERO);
    push_crlf();
    push_byte(CH_T);
    push_crlf();
    push_crlf();
    // A size line with no hex digit.
    push(MODE_CHUNK, 8'h00, 32'd0);
    push_byte(CH_G);
    push_crlf();

    // Random part: mostly well-formed bodies, with broken size lines,
    // overflowing sizes and plain noise mixed in.
    while (body_items_to_send.size() < ITEM_TARGET) begin
      pick = $urandom_range(0, 99);
      if (pick < 40) begin
        gen_chunked_body();
      end else if (pick < 70) begin
        gen_length_body();
      end else if (pick < 78) begin
        push(MODE_CHUNK, 8'($urandom()), $urandom());
        if ($urandom_range(0, 1) != 0) push_crlf();
        push_leading_space($urandom_range(0, 2));
        push_byte(8'($urandom_range(CH_G, CH_Z)));
        repeat ($urandom_range(0, 3)) push_byte(text_byte());
        push_crlf();
      end else if (pick < 85) begin
        // Eight significant digits fill the count; the ninth overflows.
        push(MODE_CHUNK, 8'($urandom()), $urandom());
        repeat ($urandom_range(0, 2)) push_byte(CH_ZERO);
        push_byte(hex_char(4'($urandom_range(1, 15))));
        repeat ($urandom_range(8, 9)) push_byte(hex_char(4'($urandom_range(0, 15))));
        if ($urandom_range(0, 1) != 0) push_crlf();
      end else begin
        repeat ($urandom_range(1, 6)) begin
          push(2'($urandom_range(0, 3)), 8'($urandom()), $urandom());
        end
      end
    end

    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    while (body_items_to_send.size() != 0 || offering) @(negedge clk_i);
    while (predicted_results.size() != 0) @(negedge clk_i);
    repeat (DRAIN_CYCLES) @(negedge clk_i);
    if (fail_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
+incdir+rtl/core
rtl/core/hbcd_pkg.sv
rtl/core/hbcd_if.sv
rtl/core/hbcd_core.sv
rtl/core/hbcd_obuf.sv
rtl/core/http_body_chunk_deframer.sv
rtl/core/hbcd_checker.sv
bench/http_body_chunk_deframer_tb.sv
